>>> sv/rrhw_pkg.sv
// Shared types and constants for the receive ring header walker.
package rrhw_pkg;

	localparam int unsigned HDR_BYTES  = 4;
	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CFG_IDX_W  = 3;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RING_START = 3'd0,
		CFG_RING_STOP  = 3'd1,
		CFG_RING_BASE  = 3'd2,
		CFG_RING_END   = 3'd3,
		CFG_MAX_FRAME  = 3'd4
	} cfg_idx_t;

	// Input transaction
	typedef struct packed {
		logic        command;
		logic [7:0]  header_next_page;
		logic [15:0] header_byte_count;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic [15:0] seg_addr;
		logic [15:0] seg_len;
		logic        frame_ok;
		logic        length_mismatch;
		logic [7:0]  boundary_page;
		logic [15:0] next_header_addr;
		logic        last;
	} out_item_t;

	// Ring configuration
	typedef struct packed {
		logic [7:0]  start_page;
		logic [7:0]  stop_page;
		logic [15:0] base_addr;
		logic [16:0] end_addr;
		logic [15:0] max_frame;
	} ring_cfg_t;

	// Header held in the input register
	typedef struct packed {
		logic [7:0]  next_page;
		logic [15:0] byte_count;
		logic [7:0]  cur_page;
		logic [15:0] hdr_addr;
	} hdr_stage_t;

	// Decoded results of one header
	typedef struct packed {
		logic [1:0] n_res;
		out_item_t  res0;
		out_item_t  res1;
	} hdr_res_t;

endpackage

>>> sv/rrhw_hdr_calc.sv
// Header decode: page distance, length checks and copy segment split.
module rrhw_hdr_calc import rrhw_pkg::*; (
	input  ring_cfg_t  cfg,
	input  hdr_stage_t hdr,
	output hdr_res_t   res
);

	logic [7:0]  pages_raw;
	logic [7:0]  pages;
	logic [15:0] len;
	logic        mis;
	logic        ok;
	logic [7:0]  bnd_raw;
	logic [7:0]  bnd;
	logic [7:0]  nxt_off;
	logic [15:0] nha;
	logic [15:0] src;
	logic [15:0] blen;
	logic [16:0] span_end;
	logic [16:0] first_w;
	logic [15:0] first;
	logic        over_end;
	logic        src_in;
	out_item_t   base_item;

	// Page distance with ring wraparound, minus header page(s)
	always_comb begin
		if (hdr.next_page >= hdr.cur_page) begin
			pages_raw = hdr.next_page - hdr.cur_page;
		end else begin
			pages_raw = (hdr.next_page - cfg.start_page) + (cfg.stop_page - hdr.cur_page);
		end
		pages = pages_raw - 8'd1;
		// header spills into the following page
		if ({1'b0, hdr.byte_count[7:0]} > 9'(256 - HDR_BYTES)) begin
			pages = pages_raw - 8'd2;
		end
	end

	assign len = {pages, hdr.byte_count[7:0]};
	assign mis = (len != hdr.byte_count);
	assign ok  = (len <= cfg.max_frame) && (hdr.next_page >= cfg.start_page)
		&& (hdr.next_page < cfg.stop_page);

	// Boundary page wraps to the last ring page
	assign bnd_raw = hdr.next_page - 8'd1;
	assign bnd     = (bnd_raw < cfg.start_page) ? (cfg.stop_page - 8'd1) : bnd_raw;
	assign nxt_off = hdr.next_page - cfg.start_page;
	assign nha     = cfg.base_addr + {nxt_off, 8'h00};

	// Body segment and its split at the ring end
	assign src      = hdr.hdr_addr + 16'(HDR_BYTES);
	assign blen     = len - 16'(HDR_BYTES);
	assign span_end = {1'b0, src} + {1'b0, blen};
	assign over_end = span_end > cfg.end_addr;
	assign src_in   = {1'b0, src} < cfg.end_addr;
	assign first_w  = cfg.end_addr - {1'b0, src};
	assign first    = first_w[15:0];

	always_comb begin
		base_item                  = '0;
		base_item.frame_ok         = ok;
		base_item.length_mismatch  = mis;
		base_item.boundary_page    = bnd;
		base_item.next_header_addr = nha;
		base_item.last             = 1'b1;

		res.n_res = 2'd1;
		res.res0  = base_item;
		res.res1  = base_item;
		res.res1.seg_addr = cfg.base_addr;
		res.res1.seg_len  = blen - first;

		if (ok) begin
			if (over_end && src_in) begin
				res.n_res         = 2'd2;
				res.res0.seg_addr = src;
				res.res0.seg_len  = first;
				res.res0.last     = 1'b0;
			end else if (over_end) begin
				res.res0.seg_addr = cfg.base_addr;
				res.res0.seg_len  = blen;
			end else begin
				res.res0.seg_addr = src;
				res.res0.seg_len  = blen;
			end
		end
	end

endmodule

>>> sv/rx_ring_header_walker.sv
// Top level of the receive ring header walker: registers, handshakes, result buffer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | in        | in_valid / in_ready     | in_data (in_item_t)
//  out     | out       | out_valid / out_ready   | out_data (out_item_t)
//  cfg     | in        | cfg_wr_en, no wait      | cfg_index, cfg_wdata (17 bits)
//
// A header is registered on acceptance and decoded from that register into a
// result register plus one pending slot for the second half of a wrapped frame.
// A frame that wraps the ring end gives two results through the single result
// port, and the next header waits until both are taken. Re-init commands move
// the read page on acceptance and give no result. Reset loads the default ring
// layout and read page start + 1. An out stall holds the result and the pending
// slot; input keeps flowing while the result register drains.
module rx_ring_header_walker import rrhw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ring_cfg_t  cfg_q;
	logic [7:0] read_page_q;
	logic       s1_valid_s1;
	hdr_stage_t hdr_s1;
	hdr_res_t   res;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       pend_valid_q;
	out_item_t  pend_q;
	logic       in_fire;
	logic       out_fire;
	logic       buf_free;
	logic       s1_adv;
	logic [7:0] cur_off;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_page <= 8'd76;
			cfg_q.stop_page  <= 8'd128;
			cfg_q.base_addr  <= 16'd19456;
			cfg_q.end_addr   <= 17'd32768;
			cfg_q.max_frame  <= 16'd2048;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RING_START: cfg_q.start_page <= cfg_wdata[7:0];
				CFG_RING_STOP:  cfg_q.stop_page  <= cfg_wdata[7:0];
				CFG_RING_BASE:  cfg_q.base_addr  <= cfg_wdata[15:0];
				CFG_RING_END:   cfg_q.end_addr   <= cfg_wdata;
				CFG_MAX_FRAME:  cfg_q.max_frame  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Handshake control
	assign out_fire  = out_valid_q && out_ready;
	assign buf_free  = !out_valid_q || (out_fire && !pend_valid_q);
	assign s1_adv    = s1_valid_s1 && buf_free;
	assign in_ready  = !s1_valid_s1 || s1_adv;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Read page tracking, updated as each transaction is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_page_q <= 8'd77;
		end else if (in_fire) begin
			read_page_q <= in_data.command ? (cfg_q.start_page + 8'd1)
				: in_data.header_next_page;
		end
	end

	// Input register; re-init commands do not enter it
	assign cur_off = read_page_q - cfg_q.start_page;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= !in_data.command;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hdr_s1.next_page  <= in_data.header_next_page;
			hdr_s1.byte_count <= in_data.header_byte_count;
			hdr_s1.cur_page   <= read_page_q;
			hdr_s1.hdr_addr   <= cfg_q.base_addr + {cur_off, 8'h00};
		end
	end

	rrhw_hdr_calc u_calc (
		.cfg (cfg_q),
		.hdr (hdr_s1),
		.res (res)
	);

	// Result register and pending second segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_fire && pend_valid_q) begin
			pend_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= (res.n_res == 2'd2);
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && pend_valid_q) begin
			out_q <= pend_q;
		end else if (s1_adv) begin
			out_q  <= res.res0;
			pend_q <= res.res1;
		end
	end

	// Pending segment only exists behind a shown first segment
	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending segment without shown result");

	// First half of a split is never marked last
	a_split_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !out_q.last)
		else $error("split first segment marked last");

	// Second half of a split closes the frame
	a_split_second: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> pend_q.last && pend_q.frame_ok)
		else $error("split second segment malformed");

	// Re-init lands on start plus one
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.command && !cfg_wr_en
		|=> read_page_q == $past(cfg_q.start_page) + 8'd1)
		else $error("re-init read page wrong");

	// No new header is taken while the decode stage is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !buf_free |-> !in_ready)
		else $error("input accepted over a blocked decode stage");

endmodule

>>> tb/rx_ring_header_walker_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the receive ring header walker: random headers, shadow ring model.
module rx_ring_header_walker_test import rrhw_pkg::*; ();

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_REINIT = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	rx_ring_header_walker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Shadow of the ring layout and of the block's read page
	ring_cfg_t  ring;
	logic [7:0] read_page;
	// Segments still owed by the block, oldest first
	out_item_t  expected_segs[$];
	// Headers waiting to be offered, and the page the generator believes is current
	in_item_t   header_q[$];
	logic [7:0] gen_page;

	int err_count = 0;
	int cycles = 0;
	bit in_took = 1'b0;
	bit out_took = 1'b0;
	int hold_reqs = 0;

	function automatic logic [15:0] header_addr(logic [7:0] page);
		logic [7:0] off;
		off = page - ring.start_page;
		return ring.base_addr + {off, 8'h00};
	endfunction

	// Walk one header through the ring and queue the segments it yields
	function automatic void walk_header(in_item_t it);
		logic [7:0]  cur, nxt, pages, bnd;
		logic [15:0] hdr, len, src, blen, first;
		logic [16:0] reach;
		logic        ok, mis;
		out_item_t   seg;
		if (it.command == CMD_REINIT) begin
			read_page = ring.start_page + 8'd1;
			return;
		end
		cur = read_page;
		nxt = it.header_next_page;
		hdr = header_addr(cur);
		// page distance, wrapping through the ring when next is behind
		if (nxt >= cur)
			pages = nxt - cur;
		else
			pages = (nxt - ring.start_page) + (ring.stop_page - cur);
		pages = pages - 8'd1;
		if (it.header_byte_count[7:0] > 8'd252)
			pages = pages - 8'd1;
		len = {pages, it.header_byte_count[7:0]};
		mis = (len != it.header_byte_count);
		ok = (len <= ring.max_frame) && (nxt >= ring.start_page) &&
			(nxt < ring.stop_page);
		read_page = nxt;
		bnd = nxt - 8'd1;
		if (bnd < ring.start_page)
			bnd = ring.stop_page - 8'd1;
		seg = '0;
		seg.frame_ok = ok;
		seg.length_mismatch = mis;
		seg.boundary_page = bnd;
		seg.next_header_addr = header_addr(nxt);
		seg.last = 1'b1;
		// corrupt frame: a single empty marker
		if (!ok) begin
			expected_segs.push_back(seg);
			return;
		end
		src = hdr + 16'(HDR_BYTES);
		blen = len - 16'(HDR_BYTES);
		reach = {1'b0, src} + {1'b0, blen};
		if (reach > ring.end_addr && {1'b0, src} < ring.end_addr) begin
			// body runs past the ring end: split and resume at the base
			first = 16'(ring.end_addr - {1'b0, src});
			seg.seg_addr = src;
			seg.seg_len = first;
			seg.last = 1'b0;
			expected_segs.push_back(seg);
			seg.seg_addr = ring.base_addr;
			seg.seg_len = blen - first;
			seg.last = 1'b1;
			expected_segs.push_back(seg);
		end else if (reach > ring.end_addr) begin
			seg.seg_addr = ring.base_addr;
			seg.seg_len = blen;
			expected_segs.push_back(seg);
		end else begin
			seg.seg_addr = src;
			seg.seg_len = blen;
			expected_segs.push_back(seg);
		end
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic check_segment(out_item_t got);
		out_item_t want;
		if (expected_segs.size() == 0) begin
			report_mismatch("segment with none pending, seg_addr", got.seg_addr, 0);
			return;
		end
		want = expected_segs.pop_front();
		if (got.seg_addr !== want.seg_addr)
			report_mismatch("seg_addr", got.seg_addr, want.seg_addr);
		if (got.seg_len !== want.seg_len)
			report_mismatch("seg_len", got.seg_len, want.seg_len);
		if (got.frame_ok !== want.frame_ok)
			report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
		if (got.length_mismatch !== want.length_mismatch)
			report_mismatch("length_mismatch", got.length_mismatch, want.length_mismatch);
		if (got.boundary_page !== want.boundary_page)
			report_mismatch("boundary_page", got.boundary_page, want.boundary_page);
		if (got.next_header_addr !== want.next_header_addr)
			report_mismatch("next_header_addr", got.next_header_addr, want.next_header_addr);
		if (got.last !== want.last)
			report_mismatch("last", got.last, want.last);
	endtask

	// Monitor: sample both handshakes at the rising edge; results are checked
	// before the header taken at the same edge adds its own
	always @(posedge clk) begin
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (out_took)
			check_segment(out_data);
		if (in_took)
			walk_header(in_data);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[rx_ring_header_walker] ERROR");
			$finish;
		end
	end

	// Header driver: random gap before each transaction, quiet stretches now and then
	int in_gap = 0;
	bit in_quiet = 1'b0;
	always @(negedge clk) begin : drive_headers
		logic     nv;
		in_item_t nd;
		nv = in_valid;
		nd = in_data;
		if (in_took)
			nv = 1'b0;
		if (!nv) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (header_q.size() > 0) begin
				nd = header_q.pop_front();
				nv = 1'b1;
				if ($urandom_range(0, 39) == 0)
					in_quiet = !in_quiet;
				in_gap = in_quiet ? 0 : $urandom_range(0, 13);
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// Segment receiver: per-transaction stall plus an occasional long hold-off
	int out_wait = 0;
	int hold_left = 0;
	int hold_served = 0;
	bit out_quiet = 1'b0;
	always @(negedge clk) begin : drive_ready
		logic nr;
		if (out_took) begin
			if ($urandom_range(0, 39) == 0)
				out_quiet = !out_quiet;
			out_wait = out_quiet ? 0 : $urandom_range(0, 13);
		end
		if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			nr = 1'b0;
		end else if (out_wait > 0) begin
			out_wait--;
			nr = 1'b0;
		end else begin
			nr = 1'b1;
		end
		out_ready <= nr;
	end

	function automatic void queue_item(logic cmd, logic [7:0] nxt, logic [15:0] cnt);
		in_item_t it;
		it.command = cmd;
		it.header_next_page = nxt;
		it.header_byte_count = cnt;
		header_q.push_back(it);
		gen_page = (cmd == CMD_REINIT) ? ring.start_page + 8'd1 : nxt;
	endfunction

	// Well-formed header for a frame of len bytes; flip corrupts the stated count
	function automatic void queue_frame(int unsigned len, logic [15:0] flip);
		int unsigned span, dest;
		span = (len >> 8) + 1 + (((len & 255) > 252) ? 1 : 0);
		dest = gen_page + span;
		if (ring.stop_page > ring.start_page && dest >= ring.stop_page)
			dest = dest - ring.stop_page + ring.start_page;
		queue_item(CMD_HEADER, dest[7:0], len[15:0] ^ flip);
	endfunction

	function automatic void queue_random(int n);
		int unsigned pick, len;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: len = $urandom_range(0, 3);
				1, 2: len = $urandom_range(300, 1600);
				3: len = $urandom_range(0, int'(ring.max_frame) + 300);
				default: len = $urandom_range(4, 300);
			endcase
			if (len > 65535)
				len = 65535;
			if (pick < 70)
				queue_frame(len, 16'h0000);
			else if (pick < 80)
				queue_frame(len, 16'd1 << $urandom_range(0, 15));
			else if (pick < 88)
				queue_item(CMD_HEADER, 8'($urandom), 16'($urandom));
			else if (pick < 94)
				queue_item(CMD_HEADER, (pick[0] ? ring.stop_page : ring.start_page - 8'd4) +
					8'($urandom_range(0, 3)), 16'(len));
			else
				queue_item(CMD_REINIT, 8'($urandom), 16'($urandom));
		end
	endfunction

	// Wait until every header is taken and every segment has come back
	task automatic finish_phase();
		do
			@(posedge clk);
		while (header_q.size() != 0 || in_valid || expected_segs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_RING_START: ring.start_page = val[7:0];
			CFG_RING_STOP:  ring.stop_page = val[7:0];
			CFG_RING_BASE:  ring.base_addr = val[15:0];
			CFG_RING_END:   ring.end_addr = val[16:0];
			CFG_MAX_FRAME:  ring.max_frame = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_ring(logic [7:0] st, logic [7:0] sp, logic [15:0] base,
			logic [16:0] end_a, logic [15:0] mx);
		set_reg(CFG_RING_START, 17'(st));
		set_reg(CFG_RING_STOP, 17'(sp));
		set_reg(CFG_RING_BASE, 17'(base));
		set_reg(CFG_RING_END, end_a);
		set_reg(CFG_MAX_FRAME, 17'(mx));
	endtask

	task automatic random_ring();
		int unsigned st, sp, base, end_a, mx;
		st = $urandom_range(0, 200);
		sp = st + $urandom_range(6, 55);
		base = $urandom_range(0, 65535);
		if ($urandom_range(0, 1) == 0)
			base = base & 32'hFF00;
		end_a = base + (sp - st) * 256;
		if (end_a > 65536)
			end_a = 65536;
		if ($urandom_range(0, 3) == 0)
			end_a = $urandom_range(0, 65536);
		case ($urandom_range(0, 2))
			0: mx = 2048;
			1: mx = 1536;
			default: mx = $urandom_range(64, 65535);
		endcase
		set_ring(st[7:0], sp[7:0], base[15:0], end_a[16:0], mx[15:0]);
	endtask

	initial begin
		ring.start_page = 8'd76;
		ring.stop_page = 8'd128;
		ring.base_addr = 16'd19456;
		ring.end_addr = 17'd32768;
		ring.max_frame = 16'd2048;
		read_page = 8'd77;
		gen_page = 8'd77;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Default ring: edges of length, checks, re-init and wrap split
		queue_frame(60, 16'h0000);
		queue_frame(4, 16'h0000);      // empty body
		queue_frame(252, 16'h0000);    // last page just fits the header
		queue_frame(253, 16'h0000);    // spills one more page
		queue_frame(2048, 16'h0000);   // at the size limit
		queue_frame(2049, 16'h0000);   // one past the limit
		queue_frame(1500, 16'h0100);   // stated count disagrees
		queue_frame(2, 16'h0000);      // short length, body wraps huge
		queue_item(CMD_HEADER, 8'd0, 16'h0000);
		queue_item(CMD_HEADER, 8'd255, 16'hFFFF);
		queue_item(CMD_HEADER, 8'd128, 16'd100);   // next page equals stop
		queue_item(CMD_REINIT, 8'd255, 16'hFFFF);
		queue_item(CMD_HEADER, 8'd126, 16'd300);   // jump close to the ring end
		queue_frame(1000, 16'h0000);   // crosses the ring end
		queue_frame(600, 16'h0000);
		queue_item(CMD_HEADER, gen_page, 16'd64);  // next page equals current
		queue_item(CMD_REINIT, 8'd0, 16'd0);
		queue_frame(64, 16'h0000);
		queue_random(80);
		finish_phase();

		// Widest ring, every length accepted; receiver holds off to fill the block
		set_ring(8'd0, 8'd255, 16'd0, 17'd65536, 16'd65535);
		queue_item(CMD_REINIT, 8'd0, 16'd0);
		queue_frame(0, 16'h0000);
		queue_item(CMD_HEADER, 8'd254, 16'hFFFF);
		queue_frame(1000, 16'h0000);
		hold_reqs++;
		queue_random(90);
		finish_phase();

		// Degenerate ring: start above stop, no frame can pass
		set_ring(8'd255, 8'd0, 16'd65535, 17'd0, 16'd0);
		queue_item(CMD_REINIT, 8'd0, 16'd0);
		queue_random(20);
		finish_phase();

		// End address inside the ring: upper half copies from the base
		set_reg(CFG_IDX_UNUSED, 17'($urandom));
		set_ring(8'd16, 8'd80, 16'h1000, 17'h3000, 16'd2048);
		queue_item(CMD_REINIT, 8'd0, 16'd0);
		queue_item(CMD_HEADER, 8'd50, 16'd300);
		queue_frame(300, 16'h0000);
		queue_random(80);
		finish_phase();

		// Random ring layouts
		repeat (4) begin
			random_ring();
			queue_item(CMD_REINIT, 8'($urandom), 16'($urandom));
			if ($urandom_range(0, 2) == 0)
				hold_reqs++;
			queue_random(100);
			finish_phase();
		end

		if (err_count == 0)
			$display("[rx_ring_header_walker] OK");
		else
			$display("[rx_ring_header_walker] ERROR");
		$finish;
	end

endmodule
